// File: src/fuzzy_membership_eval_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fuzzy membership evaluator
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef FUZZY_MEMBERSHIP_EVAL_DEFINES_SVH
`define FUZZY_MEMBERSHIP_EVAL_DEFINES_SVH
`ifndef SYNTHESIS
`define FME_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FME_ASSERT(label, clk, rst_n, prop, msg)
`define FME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/fme_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy membership package
// Shared constants and codes of the membership evaluator.
// ----------------------------------------------------------------------------
package fme_pkg;
    localparam int SampleBitsDefault = 16;
    localparam int FracBitsDefault   = 16;
    localparam int CfgIdxBits        = 3;

    typedef enum logic [1:0] {
        MODE_TRI   = 2'd0,
        MODE_SHLD  = 2'd1,
        MODE_SCURV = 2'd2,
        MODE_PI    = 2'd3
    } curve_mode_t;

    localparam logic [CfgIdxBits-1:0] REG_MODE  = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_FALL  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_A     = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_B     = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_C     = 3'd4;

    // shaping applied after the ratio
    typedef enum logic [2:0] {
        SH_ZERO  = 3'd0,
        SH_ONE   = 3'd1,
        SH_LIN   = 3'd2,
        SH_SQ    = 3'd3,
        SH_ONESQ = 3'd4
    } shape_t;
endpackage

// File: src/fme_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Computes floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "fuzzy_membership_eval_defines.svh"
module fme_divider
    import fme_pkg::*;
#(
    parameter int DW = 17,
    parameter int QW = 17,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] out_tag
);
    // num <= den, so the quotient fits QW = FRAC+1 bits
    logic [QW:0]   vld_reg;
    logic [DW:0]   rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [TW-1:0] tag_reg [QW+1];

    always_comb
    begin
        rem_reg[0] = {1'b0, num};
        den_reg[0] = den;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW+1:0] rem_next;
        logic [DW+1:0] diff_next;
        logic [DW:0]   rem_sel;
        logic          bit_q;
        // first step compares without shifting (integer bit of quotient)
        assign rem_next  = (i == 0) ? {1'b0, rem_reg[i]} : {rem_reg[i], 1'b0};
        assign diff_next = rem_next - {2'b00, den_reg[i]};
        assign bit_q     = !diff_next[DW+1];
        assign rem_sel   = bit_q ? diff_next[DW:0] : rem_next[DW:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_sel;
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], bit_q};
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = q_reg[QW];
    assign out_tag   = tag_reg[QW];

    `FME_ASSERT(a_div_noflow, clk, rst_n, !en |=> $stable(vld_reg[QW]), "divider moved while stalled")
    `FME_ASSERT(a_div_first, clk, rst_n, en && vld_reg[0] && (rem_reg[0][DW-1:0] <= den_reg[0]) && den_reg[0] != '0 |=> !(q_reg[1][0] && rem_reg[1] >= {1'b0, den_reg[1]}), "remainder not reduced")
    `FME_ASSERT(a_div_q, clk, rst_n, en |=> vld_reg[1] == $past(vld_reg[0]), "valid lost at entry")
endmodule

// File: src/fuzzy_membership_eval.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator
// Maps a signed crisp sample to a membership degree under a configurable
// triangle, shoulder, S or Pi curve.
// ----------------------------------------------------------------------------
// Usage: sample words enter on sample_valid/sample_ready; results leave on
// result_valid/result_ready as membership (1.0 = 2^FRAC_BITS) and
// param_error. Configuration uses cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block leaves it unchecked.
// Throughput: one word per clock while results are taken. The divider
// resolves one quotient bit per stage (2 front stages, FRAC+1 divider
// stages, a squaring stage and a finishing stage).
// The whole pipeline advances when the output register is empty or is being
// taken; a stalled receiver freezes every stage, so nothing is lost.
// Reset clears all valid bits and sets every configuration register to zero
// (triangle over 0,0,0).
// ----------------------------------------------------------------------------
`include "fuzzy_membership_eval_defines.svh"
module fuzzy_membership_eval
    import fme_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDefault,
    parameter int FRAC_BITS   = FracBitsDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CfgIdxBits-1:0]  cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [FRAC_BITS:0]     membership,
    output logic                   param_error
);
    localparam int DW = SAMPLE_BITS + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int TW = 4;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    typedef struct packed {
        logic   err;
        logic   inv;
        shape_t shape;
    } tag_t;

    curve_mode_t                    mode_reg;
    logic                           fall_reg;
    logic signed [SAMPLE_BITS-1:0]  a_reg, b_reg, c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TRI;
            fall_reg <= 1'b0;
            a_reg    <= '0;
            b_reg    <= '0;
            c_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg <= curve_mode_t'(cfg_data[1:0]);
                REG_FALL: fall_reg <= cfg_data[0];
                REG_A:    a_reg <= cfg_data;
                REG_B:    b_reg <= cfg_data;
                REG_C:    c_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    logic en;
    assign en           = !result_valid || result_ready;
    assign sample_ready = en;

    // stage 1: register sample
    logic                          v1_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= sample_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            x1_reg <= sample;
    end

    // stage 2: classify, pick numerator / denominator
    logic signed [SAMPLE_BITS:0] x, a, b, c;
    logic signed [SAMPLE_BITS+1:0] x2, ab;
    logic [DW-1:0] num_next, den_next;
    tag_t          tag_next;
    logic          err;
    logic          down;
    logic signed [SAMPLE_BITS:0] lo, hi;

    always_comb
    begin
        x = {x1_reg[SAMPLE_BITS-1], x1_reg};
        a = {a_reg[SAMPLE_BITS-1], a_reg};
        b = {b_reg[SAMPLE_BITS-1], b_reg};
        c = {c_reg[SAMPLE_BITS-1], c_reg};
        err = (a > b) || ((mode_reg == MODE_TRI || mode_reg == MODE_PI) && b > c);
        num_next = '0;
        den_next = '0;
        tag_next = '{err: err, inv: 1'b0, shape: SH_ZERO};
        lo = a;
        hi = b;
        down = fall_reg;
        if (mode_reg == MODE_PI && !(x < b))
        begin
            lo = b;
            hi = c;
            down = 1'b1;
        end
        else if (mode_reg == MODE_PI)
        begin
            down = 1'b0;
        end
        x2 = {x, 1'b0};
        ab = {lo[SAMPLE_BITS], lo} + {hi[SAMPLE_BITS], hi};
        if (!err)
        begin
            unique case (mode_reg)
                MODE_TRI:
                begin
                    if (x <= a || x > c)
                        tag_next.shape = SH_ZERO;
                    else if (x <= b)
                    begin
                        tag_next.shape = SH_LIN;
                        num_next = DW'(x - a);
                        den_next = DW'(b - a);
                    end
                    else
                    begin
                        tag_next.shape = SH_LIN;
                        num_next = DW'(c - x);
                        den_next = DW'(c - b);
                    end
                end
                MODE_SHLD:
                begin
                    if (x <= a)
                        tag_next.shape = down ? SH_ONE : SH_ZERO;
                    else if (x > b)
                        tag_next.shape = down ? SH_ZERO : SH_ONE;
                    else
                    begin
                        tag_next.shape = SH_LIN;
                        num_next = down ? DW'(b - x) : DW'(x - a);
                        den_next = DW'(b - a);
                    end
                end
                default:
                begin
                    tag_next.inv = down;
                    den_next = DW'(hi - lo);
                    if (x <= lo)
                        tag_next.shape = SH_ZERO;
                    else if (x2 <= ab)
                    begin
                        tag_next.shape = SH_SQ;
                        num_next = DW'(x - lo);
                    end
                    else if (x <= hi)
                    begin
                        tag_next.shape = SH_ONESQ;
                        num_next = DW'(hi - x);
                    end
                    else
                        tag_next.shape = SH_ONE;
                end
            endcase
        end
    end

    logic          v2_reg;
    logic [DW-1:0] num2_reg, den2_reg;
    tag_t          tag2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num2_reg <= num_next;
            den2_reg <= den_next;
            tag2_reg <= tag_next;
        end
    end

    logic          vd;
    logic [QW-1:0] qd;
    logic [TW:0]   tagd_raw;
    tag_t          tagd;

    fme_divider #(.DW(DW), .QW(QW), .TW(TW+1)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .num      (num2_reg),
        .den      (den2_reg),
        .in_tag   (tag2_reg),
        .out_valid(vd),
        .quo      (qd),
        .out_tag  (tagd_raw)
    );
    assign tagd = tag_t'(tagd_raw);

    // ratio: zero denominator means ONE; num <= den so no cap needed otherwise
    logic [QW-1:0] r;
    assign r = (qd > ONE) ? ONE : qd;

    // stage: square
    logic            v3_reg;
    logic [2*QW-1:0] sq3_reg;
    logic [QW-1:0]   r3_reg;
    tag_t            tag3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= vd;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq3_reg  <= r * r;
            r3_reg   <= r;
            tag3_reg <= tagd;
        end
    end

    // finish
    logic [2*QW:0] sq2;
    logic [QW-1:0] v_sq, m_pre, m_next;
    always_comb
    begin
        sq2  = {sq3_reg, 1'b0} >> FRAC_BITS;
        v_sq = (sq2 > (2*QW+1)'(ONE)) ? ONE : sq2[QW-1:0];
        unique case (tag3_reg.shape)
            SH_ONE:   m_pre = ONE;
            SH_LIN:   m_pre = r3_reg;
            SH_SQ:    m_pre = v_sq;
            SH_ONESQ: m_pre = ONE - v_sq;
            default:  m_pre = '0;
        endcase
        if (tag3_reg.err)
            m_next = '0;
        else if (tag3_reg.inv)
            m_next = ONE - m_pre;
        else
            m_next = m_pre;
    end

    logic          out_v_reg;
    logic [QW-1:0] mem_reg;
    logic          err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem_reg <= m_next;
            err_reg <= tag3_reg.err;
        end
    end

    assign result_valid = out_v_reg;
    assign membership   = mem_reg;
    assign param_error  = err_reg;

    `FME_ASSERT(a_range, clk, rst_n, result_valid |-> membership <= ONE, "membership above one")
    `FME_ASSERT(a_err_zero, clk, rst_n, result_valid && param_error |-> membership == '0, "error with nonzero membership")
    `FME_ASSERT(a_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(membership), "result dropped under stall")
endmodule
